@@ hdl/sac_pkg.sv @@
// Shared types and constants for the set-associative write-back cache.
// No dependencies; the cache top level takes these by scoped name.
package sac_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OFS_W  = 2;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_t;

endpackage

@@ hdl/set_assoc_lru_writeback_cache.sv @@
// Set-associative LRU write-back cache, one word per block.
// Uses sac_pkg for the state type, opcodes and field widths.
//
// Usage:
//   Input channel in_* carries one access per beat: opcode (read/write), byte
//   address, write data and the word backing memory holds at that address.
//   Output channel out_* returns exactly one result beat per access: read
//   data, hit, and an optional backing-memory write (address and data).
//   A beat moves on a channel when valid is high and stall is low.
// Timing:
//   The set index is address[31 -: IB] with IB = floor(log2(SETS)); the tag is
//   the bits between the index and the two offset bits.
//   One tag compare unit walks the ways of the set one per cycle, then the
//   update step loads the result register; a new access is taken only after
//   the previous one has left the update step.
//   in_stall stays high while an access is in flight.
// Reset and stall:
//   After reset the state memory is cleared one set per cycle, with in_stall
//   high. A result waits in the output register while out_stall is high; the
//   next access is accepted and scanned meanwhile and holds in its final step
//   until the register frees up.
module set_assoc_lru_writeback_cache #(
  parameter int unsigned WAYS = 4,
  parameter int unsigned SETS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_fill_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_hit,
  output logic        out_mem_write_valid,
  output logic [31:0] out_mem_write_address,
  output logic [31:0] out_mem_write_data
);

  localparam int unsigned IB   = $clog2(SETS + 1) - 1;
  localparam int unsigned NSET = 1 << IB;
  localparam int unsigned TB   = sac_pkg::ADDR_W - sac_pkg::OFS_W - IB;
  localparam int unsigned WB   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RW   = WB;
  localparam int unsigned NENT = NSET << WB;
  localparam int unsigned MW   = WAYS * (2 + RW);
  localparam int unsigned DW   = sac_pkg::DATA_W;

  // Memories: tag and word per entry, one state row (valid, dirty, rank) per set
  logic [TB-1:0] tag_mem  [NENT];
  logic [DW-1:0] word_mem [NENT];
  logic [MW-1:0] meta_mem [NSET];

  sac_pkg::state_t state_r, state_nxt;

  logic [IB-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [WB-1:0] cmp_way_r, cmp_way_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Latched access
  logic          op_r;
  logic [IB-1:0] set_r;
  logic [TB-1:0] tag_r;
  logic [DW-1:0] wdata_r;
  logic [DW-1:0] fdata_r;

  // Scan results
  logic          hit_r, hit_nxt;
  logic [WB-1:0] hit_way_r, hit_way_nxt;
  logic [DW-1:0] hit_word_r, hit_word_nxt;
  logic          inv_found_r, inv_found_nxt;
  logic [WB-1:0] inv_way_r, inv_way_nxt;
  logic [WB-1:0] lru_way_r, lru_way_nxt;
  logic [RW-1:0] lru_rank_r, lru_rank_nxt;
  logic [TB-1:0] vic_tag_r, vic_tag_nxt;
  logic [DW-1:0] vic_word_r, vic_word_nxt;

  // Memory read data
  logic [TB-1:0] tag_rd_r;
  logic [DW-1:0] word_rd_r;
  logic [MW-1:0] meta_rd_r;

  // Output registers
  logic [DW-1:0] out_rdata_r;
  logic          out_hit_r;
  logic          out_mwv_r;
  logic [31:0]   out_mwa_r;
  logic [DW-1:0] out_mwd_r;

  logic [WAYS-1:0]         meta_valid;
  logic [WAYS-1:0]         meta_dirty;
  logic [WAYS-1:0][RW-1:0] meta_rank;

  logic                    accept;
  logic                    upd_go;
  logic                    scan_last;
  logic [IB-1:0]           in_set;
  logic [TB-1:0]           in_tag;
  logic [IB+WB-1:0]        ent_rd_idx;
  logic [IB-1:0]           meta_rd_idx;

  logic                    tag_we;
  logic                    meta_we;
  logic [IB-1:0]           meta_wa;
  logic [MW-1:0]           meta_wd;

  logic [WB-1:0]           way_sel;
  logic                    dirty_sel;
  logic                    vic_wb;
  logic                    new_dirty;
  logic [DW-1:0]           new_word;
  logic [RW-1:0]           rank_sel;
  logic [WAYS-1:0]         new_valid;
  logic [WAYS-1:0]         new_dirty_v;
  logic [WAYS-1:0][RW-1:0] new_rank;
  logic [DW-1:0]           res_rdata;
  logic                    res_mwv;
  logic [31:0]             res_mwa;
  logic [DW-1:0]           res_mwd;

  assign meta_valid = meta_rd_r[WAYS-1:0];
  assign meta_dirty = meta_rd_r[2*WAYS-1:WAYS];
  assign meta_rank  = meta_rd_r[MW-1:2*WAYS];

  assign in_set    = in_address[31 -: IB];
  assign in_tag    = in_address[31-IB:sac_pkg::OFS_W];
  assign accept    = in_valid && !in_stall;
  assign scan_last = (cmp_way_r == WB'(WAYS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sac_pkg::S_CLEAR: begin
        if (clr_cnt_r == IB'(NSET - 1)) state_nxt = sac_pkg::S_IDLE;
      end
      sac_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sac_pkg::S_SCAN;
      end
      sac_pkg::S_SCAN: begin
        if (scan_last) state_nxt = sac_pkg::S_UPDATE;
      end
      sac_pkg::S_UPDATE: begin
        if (!out_valid_r || !out_stall) state_nxt = sac_pkg::S_IDLE;
      end
      default: state_nxt = sac_pkg::S_CLEAR;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    upd_go   = 1'b0;
    meta_we  = 1'b0;
    tag_we   = 1'b0;
    meta_wa  = set_r;
    meta_wd  = {new_rank, new_dirty_v, new_valid};
    case (state_r)
      sac_pkg::S_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_cnt_r;
        meta_wd = '0;
      end
      sac_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      sac_pkg::S_SCAN: begin
      end
      sac_pkg::S_UPDATE: begin
        upd_go  = !out_valid_r || !out_stall;
        meta_we = upd_go;
        tag_we  = upd_go;
      end
      default: begin
      end
    endcase
  end

  assign clr_cnt_nxt = (state_r == sac_pkg::S_CLEAR) ? clr_cnt_r + IB'(1) : clr_cnt_r;
  assign cmp_way_nxt = (state_r == sac_pkg::S_SCAN) ? cmp_way_r + WB'(1) : '0;
  assign out_valid_nxt = upd_go ? 1'b1 : (out_valid_r && out_stall);

  // Read the set at the accept edge, then step one way per cycle
  assign ent_rd_idx  = (state_r == sac_pkg::S_IDLE) ? {in_set, WB'(0)}
                                                     : {set_r, cmp_way_r + WB'(1)};
  assign meta_rd_idx = (state_r == sac_pkg::S_IDLE) ? in_set : set_r;

  // Shared compare unit: one way per cycle
  always_comb begin
    hit_nxt       = hit_r;
    hit_way_nxt   = hit_way_r;
    hit_word_nxt  = hit_word_r;
    inv_found_nxt = inv_found_r;
    inv_way_nxt   = inv_way_r;
    lru_way_nxt   = lru_way_r;
    lru_rank_nxt  = lru_rank_r;
    vic_tag_nxt   = vic_tag_r;
    vic_word_nxt  = vic_word_r;
    if (accept) begin
      hit_nxt       = 1'b0;
      inv_found_nxt = 1'b0;
    end else if (state_r == sac_pkg::S_SCAN) begin
      if (!hit_r && meta_valid[cmp_way_r] && (tag_rd_r == tag_r)) begin
        hit_nxt      = 1'b1;
        hit_way_nxt  = cmp_way_r;
        hit_word_nxt = word_rd_r;
      end
      if (!inv_found_r && !meta_valid[cmp_way_r]) begin
        inv_found_nxt = 1'b1;
        inv_way_nxt   = cmp_way_r;
      end
      // Lowest rank wins; ties keep the lower way
      if ((cmp_way_r == '0) || (meta_rank[cmp_way_r] < lru_rank_r)) begin
        lru_way_nxt  = cmp_way_r;
        lru_rank_nxt = meta_rank[cmp_way_r];
        vic_tag_nxt  = tag_rd_r;
        vic_word_nxt = word_rd_r;
      end
    end
  end

  // Update of the chosen way and the result
  always_comb begin
    way_sel   = hit_r ? hit_way_r : (inv_found_r ? inv_way_r : lru_way_r);
    dirty_sel = hit_r && meta_dirty[way_sel];
    vic_wb    = !hit_r && !inv_found_r && meta_dirty[lru_way_r];
    rank_sel  = meta_rank[way_sel];

    res_mwv   = vic_wb;
    res_mwa   = vic_wb ? {set_r, vic_tag_r, 2'b00} : 32'd0;
    res_mwd   = vic_wb ? vic_word_r : '0;
    res_rdata = '0;
    new_dirty = 1'b0;
    new_word  = hit_r ? hit_word_r : fdata_r;

    if (op_r == sac_pkg::OP_WRITE) begin
      new_word = wdata_r;
      if (dirty_sel) begin
        // write through a dirty hit and clean the block
        res_mwv   = 1'b1;
        res_mwa   = {set_r, tag_r, 2'b00};
        res_mwd   = wdata_r;
        new_dirty = 1'b0;
      end else begin
        new_dirty = 1'b1;
      end
    end else begin
      // a read hit keeps the block's dirty flag; a fill is clean
      new_dirty = dirty_sel;
      res_rdata = new_word;
    end

    new_valid   = meta_valid;
    new_dirty_v = meta_dirty;
    new_valid[way_sel]   = 1'b1;
    new_dirty_v[way_sel] = new_dirty;
    for (int w = 0; w < WAYS; w++) begin
      new_rank[w] = (meta_rank[w] > rank_sel) ? meta_rank[w] - RW'(1) : meta_rank[w];
    end
    new_rank[way_sel] = RW'(WAYS - 1);
  end

  // Memories
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[{set_r, way_sel}]  <= tag_r;
      word_mem[{set_r, way_sel}] <= new_word;
    end
    tag_rd_r  <= tag_mem[ent_rd_idx];
    word_rd_r <= word_mem[ent_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    meta_rd_r <= meta_mem[meta_rd_idx];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sac_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      cmp_way_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cmp_way_r   <= cmp_way_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      set_r   <= in_set;
      tag_r   <= in_tag;
      wdata_r <= in_write_data;
      fdata_r <= in_fill_data;
    end
    hit_r       <= hit_nxt;
    hit_way_r   <= hit_way_nxt;
    hit_word_r  <= hit_word_nxt;
    inv_found_r <= inv_found_nxt;
    inv_way_r   <= inv_way_nxt;
    lru_way_r   <= lru_way_nxt;
    lru_rank_r  <= lru_rank_nxt;
    vic_tag_r   <= vic_tag_nxt;
    vic_word_r  <= vic_word_nxt;
    if (upd_go) begin
      out_rdata_r <= res_rdata;
      out_hit_r   <= hit_r;
      out_mwv_r   <= res_mwv;
      out_mwa_r   <= res_mwa;
      out_mwd_r   <= res_mwd;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_read_data         = out_rdata_r;
  assign out_hit               = out_hit_r;
  assign out_mem_write_valid   = out_mwv_r;
  assign out_mem_write_address = out_mwa_r;
  assign out_mem_write_data    = out_mwd_r;

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == sac_pkg::S_SCAN)
    else $error("accepted beat did not start a scan");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sac_pkg::S_UPDATE))
    else $error("result appeared without an update step");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sac_pkg::S_CLEAR |-> in_stall)
    else $error("input taken during clearing pass");

  a_hit_way_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sac_pkg::S_UPDATE) && hit_r |-> meta_valid[hit_way_r])
    else $error("hit recorded on an invalid way");

  a_victim_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go && !hit_r && inv_found_r |-> !vic_wb)
    else $error("writeback issued while an invalid way was free");

endmodule
